// ----- src/btb_pkg.sv -----
// shared constants and register map for the branch target buffer
package btb_pkg;

  localparam int WAYS    = 4;
  localparam int SETS    = 128;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W   = $clog2(SETS);
  localparam int ENT_W   = WAY_W + SET_W;
  localparam int ENTRIES = 1 << ENT_W;

  localparam int PC_W    = 64;
  localparam int AGE_W   = 32;
  localparam int CNT_W   = 32;
  localparam int PEN_W   = 8;
  localparam int IN_W    = 136;
  localparam int OUT_W   = 40;

  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [APB_AW-3:0] REG_PENALTY   = 1'b0;
  localparam logic [PEN_W-1:0]  PENALTY_RESET = 8'd10;

endpackage

// ----- src/btb_apb.sv -----
// configuration register block on the apb port
module btb_apb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [btb_pkg::APB_AW-1:0]   paddr,
  input  logic [btb_pkg::APB_DW-1:0]   pwdata,
  output logic [btb_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [btb_pkg::PEN_W-1:0]    penalty
);
  import btb_pkg::*;

  logic sel_penalty;
  logic wr_en;

  assign pready      = 1'b1;
  assign sel_penalty = (paddr[APB_AW-1:2] == REG_PENALTY);
  assign wr_en       = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty <= PENALTY_RESET;
    end else if (wr_en && sel_penalty) begin
      penalty <= pwdata[PEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_penalty) begin
      prdata = {{(APB_DW-PEN_W){1'b0}}, penalty};
    end
  end

endmodule

// ----- src/branch_target_buffer.sv -----
// set-associative branch target buffer top level with way-serial lookup
//
// one transaction on the s_ side carries a branch pc, the address that
// followed it and the actual direction; one transaction on the m_ side
// returns hit, way, prediction and correctness flags and the cycle count.
// the entry memory has a single read port, so the lookup walks the ways
// one per cycle through one tag comparator and one age comparator.
// a hit ends the scan at the matching way, a miss after all WAYS ways;
// s_tready rises together with m_tvalid, so a new transaction is taken
// only once the result of the one before is in the output register.
// after reset a clearing pass zeroes all ENTRIES entries with s_tready
// low; apb writes are taken throughout.
// the result sits in an output register; if m_tready is low when the next
// result is ready, the block holds it and waits without touching the state.
// the penalty register is written through apb at byte address 0 and
// resets to 10.
module branch_target_buffer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [btb_pkg::APB_AW-1:0]   paddr,
  input  logic [btb_pkg::APB_DW-1:0]   pwdata,
  output logic [btb_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // pc[63:0], next_pc[127:64], taken[128], zero pad
  input  logic [btb_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // hit[0], way[2:1], predicted_taken[3], target_correct[4],
  // last_bit_correct[5], prev_bit_correct[6], cycle_count[38:7], zero pad
  output logic [btb_pkg::OUT_W-1:0]    m_tdata
);
  import btb_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [PC_W-1:0]  tag;
    logic [AGE_W-1:0] age;
    logic [PC_W-1:0]  target;
    logic             last_dir;
    logic             prev_dir;
  } entry_t;

  localparam logic [WAY_W-1:0] LAST_WAY  = WAY_W'(WAYS - 1);
  localparam logic [ENT_W-1:0] LAST_ENT  = ENT_W'(ENTRIES - 1);

  state_t state;

  logic [PEN_W-1:0]  penalty;
  logic [ENT_W-1:0]  clr_idx;
  logic [CNT_W-1:0]  cycle_counter;
  logic [CNT_W-1:0]  cycle_counter_next;

  logic [PC_W-1:0]   pc_r;
  logic [PC_W-1:0]   next_pc_r;
  logic              taken_r;
  logic [SET_W-1:0]  set_idx;

  logic [WAY_W-1:0]  rd_way;
  logic              issue_done;
  logic              rd_pend;
  logic [WAY_W-1:0]  cmp_way;

  logic              hit_found;
  logic [WAY_W-1:0]  hit_way;
  logic              hit_prev;
  logic              hit_last;
  logic              hit_tgt_ok;
  logic [AGE_W-1:0]  best_age;
  logic [WAY_W-1:0]  best_way;
  logic              best_last;

  entry_t            mem [ENTRIES];
  entry_t            rdata;
  entry_t            wentry;
  logic [ENT_W-1:0]  raddr;
  logic [ENT_W-1:0]  waddr;
  logic              mem_we;

  logic              in_fire;
  logic              out_free;
  logic              finish;
  logic              tag_match;
  logic              age_less;
  logic [WAY_W-1:0]  sel_way;
  logic              res_pred;
  logic              res_tgt_ok;
  logic              res_last_ok;
  logic              res_prev_ok;

  btb_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .penalty      (penalty)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_WRITE) && out_free;
  assign set_idx  = pc_r[SET_W+1:2];
  assign raddr    = {rd_way, set_idx};

  // shared comparators, one way per cycle
  assign tag_match = (rdata.tag == pc_r);
  assign age_less  = (cmp_way == '0) || (rdata.age < best_age);

  assign sel_way     = hit_found ? hit_way : best_way;
  assign res_pred    = hit_found && hit_prev;
  assign res_tgt_ok  = hit_found && hit_tgt_ok;
  assign res_last_ok = hit_found ? (hit_last == taken_r) : !taken_r;
  assign res_prev_ok = hit_found ? (hit_prev == taken_r) : !taken_r;

  always_comb begin
    cycle_counter_next = cycle_counter + CNT_W'(penalty);
    if (hit_found && (hit_prev == taken_r)) begin
      cycle_counter_next = cycle_counter + CNT_W'(1);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = clr_idx;
    wentry = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_WRITE: begin
        mem_we          = out_free;
        waddr           = {sel_way, set_idx};
        wentry.tag      = pc_r;
        wentry.age      = cycle_counter;
        wentry.target   = hit_found ? next_pc_r : '0;
        wentry.last_dir = taken_r;
        wentry.prev_dir = hit_found ? taken_r : best_last;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wentry;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      cycle_counter <= '0;
      rd_way        <= '0;
      issue_done    <= 1'b0;
      rd_pend       <= 1'b0;
      hit_found     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + ENT_W'(1);
          if (clr_idx == LAST_ENT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            rd_way     <= '0;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            hit_found  <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_pend <= !issue_done;
          if (!issue_done) begin
            if (rd_way == LAST_WAY) begin
              issue_done <= 1'b1;
            end else begin
              rd_way <= rd_way + WAY_W'(1);
            end
          end
          if (rd_pend) begin
            if (tag_match) begin
              hit_found <= 1'b1;
              state     <= ST_WRITE;
            end else if (cmp_way == LAST_WAY) begin
              state <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            cycle_counter <= cycle_counter_next;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pc_r      <= s_tdata[PC_W-1:0];
      next_pc_r <= s_tdata[2*PC_W-1:PC_W];
      taken_r   <= s_tdata[2*PC_W];
    end
    if ((state == ST_SCAN) && !issue_done) begin
      cmp_way <= rd_way;
    end
    if ((state == ST_SCAN) && rd_pend) begin
      if (tag_match) begin
        hit_way    <= cmp_way;
        hit_prev   <= rdata.prev_dir;
        hit_last   <= rdata.last_dir;
        hit_tgt_ok <= (rdata.target == next_pc_r);
      end
      if (age_less) begin
        best_age  <= rdata.age;
        best_way  <= cmp_way;
        best_last <= rdata.last_dir;
      end
    end
    if (finish) begin
      m_tdata <= {1'b0, cycle_counter_next, res_prev_ok, res_last_ok, res_tgt_ok,
                  res_pred, 2'(sel_way), hit_found};
    end
  end

endmodule
